@@ src/delimiter_string_splitter_macros.svh @@
// ----------------------------------------------------------------------------
// Delimiter string splitter assertion macros
// Concurrent assertion wrappers shared by the splitter RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef DELIMITER_STRING_SPLITTER_MACROS_SVH
`define DELIMITER_STRING_SPLITTER_MACROS_SVH

`ifndef SYNTHESIS

// Expression holds at every clock edge outside reset
`define DSS_ASSERT(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define DSS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define DSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define DSS_ASSERT(lbl, clk, rstn, expr, msg)
`define DSS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define DSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ src/dss_pkg.sv @@
// ----------------------------------------------------------------------------
// Delimiter string splitter package
// Shared constants, item and result types and configuration helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

  // Sizes
  localparam int unsigned DelimMax   = 8;
  localparam int unsigned SlotMax    = 63;
  localparam int unsigned CharW      = 8;
  localparam int unsigned LenW       = 4;
  localparam int unsigned DelimBytesW = 64;
  localparam int unsigned SlotW      = 6;
  localparam int unsigned HoldCntW   = $clog2(DelimMax + 1);
  localparam int unsigned HoldIdxW   = (DelimMax > 1) ? $clog2(DelimMax) : 1;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned QDepth     = 2;
  localparam int unsigned QPtrW      = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QDepth + 1);
  localparam int unsigned OutDataW   = 24;
  localparam int unsigned KindW      = 2;

  // Register reset values: a single space delimiter, eight slots
  localparam logic [LenW-1:0]        DelimLenRst   = LenW'(1);
  localparam logic [DelimBytesW-1:0] DelimBytesRst = DelimBytesW'(8'h20);
  localparam logic [SlotW-1:0]       SlotsRst      = SlotW'(8);

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DELIM_LEN   = 2'd0,
    CFG_DELIM_BYTES = 2'd1,
    CFG_OUT_SLOTS   = 2'd2
  } cfg_idx_e;

  // Result kinds
  typedef enum logic [KindW-1:0] {
    KIND_CHAR   = 2'd0,
    KIND_END    = 2'd1,
    KIND_REPORT = 2'd2
  } kind_e;

  // Input item classes
  typedef enum logic {
    ITEM_CHAR = 1'b0,
    ITEM_TERM = 1'b1
  } item_e;

  typedef logic [DelimMax-1:0][CharW-1:0] hold_t;

  typedef struct packed {
    item_e             cls;
    logic [CharW-1:0]  ch;
  } item_t;

  typedef struct packed {
    logic [HoldCntW-1:0]    delim_len;
    logic [DelimBytesW-1:0] delim_bytes;
    logic [SlotW-1:0]       slots;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [CharW-1:0]  ch;
    logic [SlotW-1:0]  idx;
    logic [SlotW-1:0]  found;
    logic              valid;
  } result_t;

  // One sequencer step as seen by the output side
  typedef struct packed {
    logic    step;
    logic    res_v;
    logic    done;
    result_t res;
  } step_t;

  // Clamp the delimiter length into 1..DelimMax
  function automatic logic [HoldCntW-1:0] eff_len(input logic [LenW-1:0] raw);
    logic [HoldCntW-1:0] len;
    if (raw == '0) begin
      len = HoldCntW'(1);
    end else if (int'(raw) > DelimMax) begin
      len = HoldCntW'(DelimMax);
    end else begin
      len = HoldCntW'(raw);
    end
    return len;
  endfunction

  // Clamp the slot count to SlotMax
  function automatic logic [SlotW-1:0] eff_slots(input logic [SlotW-1:0] raw);
    logic [SlotW-1:0] s;
    if (int'(raw) > SlotMax) begin
      s = SlotW'(SlotMax);
    end else begin
      s = raw;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

@@ src/dss_front.sv @@
// ----------------------------------------------------------------------------
// Splitter front end
// Accepts input items, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dss_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output      logic                         s_axis_tready_o,
  input  wire logic [dss_pkg::CharW-1:0]    s_axis_tdata_i,  // [7:0] text_char
  input  wire logic                         s_axis_tlast_i,  // end_of_text
  output      logic                         q_valid_o,
  output      dss_pkg::item_t               q_item_o,
  input  wire logic                         q_pop_i
);

  dss_pkg::item_t                  ent_q [dss_pkg::QDepth];
  logic [dss_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [dss_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [dss_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                            push;
  dss_pkg::item_t                  in_item;

  // Classify the incoming item
  always_comb begin
    in_item.cls = s_axis_tlast_i ? dss_pkg::ITEM_TERM : dss_pkg::ITEM_CHAR;
    in_item.ch  = s_axis_tlast_i ? '0 : s_axis_tdata_i;
  end

  assign s_axis_tready_o = (cnt_q != dss_pkg::QCntW'(dss_pkg::QDepth));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign q_valid_o       = (cnt_q != '0);
  assign q_item_o        = ent_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == dss_pkg::QPtrW'(dss_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i && q_valid_o) begin
      rd_ptr_d = (rd_ptr_q == dss_pkg::QPtrW'(dss_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    priority if (push && !(q_pop_i && q_valid_o)) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i && q_valid_o) begin
      cnt_d = cnt_q - 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the item payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ src/dss_engine.sv @@
// ----------------------------------------------------------------------------
// Splitter engine
// Holds back characters, matches the delimiter and steps through tokens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "delimiter_string_splitter_macros.svh"

module dss_engine (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dss_pkg::cfg_t   cfg_i,
  input  wire logic            q_valid_i,
  input  wire dss_pkg::item_t  q_item_i,
  output      logic            q_pop_o,
  input  wire logic            go_i,
  output      dss_pkg::step_t  step_o
);

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_DRAIN = 3'b010,
    MODE_FLUSH = 3'b100
  } mode_e;

  mode_e                            mode_q, mode_d;
  dss_pkg::hold_t                   hold_q, hold_d;
  logic [dss_pkg::HoldCntW-1:0]     hold_cnt_q, hold_cnt_d;
  logic                             open_q, open_d;
  logic [dss_pkg::SlotW-1:0]        tok_cnt_q, tok_cnt_d;
  logic                             exceeded_q, exceeded_d;

  logic                             pop;
  logic                             active;
  logic                             term;
  dss_pkg::hold_t                   cur_buf;
  logic [dss_pkg::HoldCntW-1:0]     cur_cnt;
  logic [dss_pkg::DelimMax-1:0]     byte_ok;
  logic                             match_en;
  logic                             match;
  logic                             do_release;
  logic                             do_close;
  logic                             do_report;
  logic [dss_pkg::HoldCntW-1:0]     drop_n;
  logic                             res_v;
  dss_pkg::result_t                 res;
  logic                             done;

  assign pop     = go_i && (mode_q == MODE_IDLE) && q_valid_i;
  assign active  = pop || (go_i && (mode_q != MODE_IDLE));
  assign term    = pop ? (q_item_i.cls == dss_pkg::ITEM_TERM) : (mode_q == MODE_FLUSH);
  assign q_pop_o = pop;

  // Append a popped character to the held window
  always_comb begin
    cur_buf = hold_q;
    cur_cnt = hold_cnt_q;
    if (pop && (q_item_i.cls == dss_pkg::ITEM_CHAR) &&
        (hold_cnt_q < dss_pkg::HoldCntW'(dss_pkg::DelimMax))) begin
      cur_buf[hold_cnt_q[dss_pkg::HoldIdxW-1:0]] = q_item_i.ch;
      cur_cnt = hold_cnt_q + 1'b1;
    end
  end

  // Compare the window front against the delimiter
  always_comb begin
    for (int i = 0; i < dss_pkg::DelimMax; i++) begin
      byte_ok[i] = (dss_pkg::HoldCntW'(i) >= cfg_i.delim_len) ||
                   (cur_buf[i] == cfg_i.delim_bytes[i*dss_pkg::CharW +: dss_pkg::CharW]);
    end
  end

  assign match_en = (cur_cnt >= cfg_i.delim_len);
  assign match    = &byte_ok;

  // Pick the action of this step
  always_comb begin
    do_release = 1'b0;
    do_close   = 1'b0;
    do_report  = 1'b0;
    drop_n     = '0;
    if (active) begin
      priority if (match_en && match) begin
        do_close = 1'b1;
        drop_n   = cfg_i.delim_len;
      end else if (match_en) begin
        do_release = 1'b1;
        drop_n     = dss_pkg::HoldCntW'(1);
      end else if (term && (cur_cnt != '0)) begin
        do_release = 1'b1;
        drop_n     = dss_pkg::HoldCntW'(1);
      end else if (term && open_q) begin
        do_close = 1'b1;
      end else if (term) begin
        do_report = 1'b1;
      end else begin
        drop_n = '0;
      end
    end
  end

  // Carry out the step on token state
  always_comb begin
    open_d     = open_q;
    tok_cnt_d  = tok_cnt_q;
    exceeded_d = exceeded_q;
    res_v      = 1'b0;
    res        = '0;
    res.kind   = dss_pkg::KIND_CHAR;

    hold_d     = cur_buf >> (dss_pkg::CharW * drop_n);
    hold_cnt_d = cur_cnt - drop_n;

    if (do_release) begin
      if (open_q) begin
        res_v    = 1'b1;
        res.ch   = cur_buf[0];
        res.idx  = tok_cnt_q;
      end else if (!exceeded_q) begin
        if (tok_cnt_q >= cfg_i.slots) begin
          exceeded_d = 1'b1;
        end else begin
          tok_cnt_d = tok_cnt_q + 1'b1;
          open_d    = 1'b1;
          res_v     = 1'b1;
          res.ch    = cur_buf[0];
          res.idx   = tok_cnt_q + 1'b1;
        end
      end
    end

    if (do_close && open_q) begin
      res_v    = 1'b1;
      res.kind = dss_pkg::KIND_END;
      res.idx  = tok_cnt_q;
      open_d   = 1'b0;
    end

    if (do_report) begin
      res_v      = 1'b1;
      res.kind   = dss_pkg::KIND_REPORT;
      res.found  = tok_cnt_q;
      res.valid  = !exceeded_q;
      tok_cnt_d  = '0;
      exceeded_d = 1'b0;
      open_d     = 1'b0;
    end
  end

  // Decide whether the current item is finished
  always_comb begin
    done   = 1'b0;
    mode_d = mode_q;
    if (active) begin
      done = term ? do_report : (hold_cnt_d < cfg_i.delim_len);
      priority if (done) begin
        mode_d = MODE_IDLE;
      end else if (term) begin
        mode_d = MODE_FLUSH;
      end else begin
        mode_d = MODE_DRAIN;
      end
    end
  end

  always_comb begin
    step_o.step  = active;
    step_o.res_v = res_v;
    step_o.done  = done;
    step_o.res   = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      hold_cnt_q <= '0;
      open_q     <= 1'b0;
      tok_cnt_q  <= '0;
      exceeded_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      hold_cnt_q <= hold_cnt_d;
      open_q     <= open_d;
      tok_cnt_q  <= tok_cnt_d;
      exceeded_q <= exceeded_d;
    end
  end

  // Window contents; only the first hold_cnt_q bytes are meaningful
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

  `DSS_ASSERT_IMPL(a_exceeded_closed, clk_i, rst_ni, exceeded_q, !open_q, "token open after slots ran out")
  `DSS_ASSERT_IMPL(a_idle_room, clk_i, rst_ni, mode_q == MODE_IDLE, hold_cnt_q < dss_pkg::HoldCntW'(dss_pkg::DelimMax), "held window full while idle")
  `DSS_ASSERT_IMPL(a_report_flushed, clk_i, rst_ni, do_report, (cur_cnt == '0) && !open_q, "report before window flushed")
  `DSS_ASSERT_NEXT(a_report_clears, clk_i, rst_ni, do_report, (tok_cnt_q == '0) && !exceeded_q && !open_q, "token state not cleared after report")

endmodule

`default_nettype wire

@@ src/dss_emit.sv @@
// ----------------------------------------------------------------------------
// Splitter result emitter
// Holds one result back to mark the last one of an item, then registers it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "delimiter_string_splitter_macros.svh"

module dss_emit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire dss_pkg::step_t                  step_i,
  output      logic                            ready_o,
  output      logic                            m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output      logic [dss_pkg::OutDataW-1:0]    m_axis_tdata_o,  // [7:0] out_char,
                                                                // [13:8] element_index,
                                                                // [19:14] elements_found,
                                                                // [20] count_valid
  output      logic [dss_pkg::KindW-1:0]       m_axis_tuser_o,  // [1:0] kind
  output      logic                            m_axis_tlast_o   // last
);

  logic              pend_v_q, pend_v_d;
  logic              pend_last_q, pend_last_d;
  dss_pkg::result_t  pend_q, pend_d;
  logic              out_v_q, out_v_d;
  dss_pkg::result_t  out_q, out_d;
  logic              out_last_q, out_last_d;
  logic              out_free;
  logic              push;
  dss_pkg::result_t  push_res;
  logic              push_last;

  assign out_free = !out_v_q || m_axis_tready_i;
  assign ready_o  = out_free && !pend_last_q;

  // Route step results through the pending slot
  always_comb begin
    pend_v_d    = pend_v_q;
    pend_last_d = pend_last_q;
    pend_d      = pend_q;
    push        = 1'b0;
    push_res    = pend_q;
    push_last   = 1'b0;
    if (out_free && pend_last_q) begin
      push        = 1'b1;
      push_last   = 1'b1;
      pend_v_d    = 1'b0;
      pend_last_d = 1'b0;
    end else if (step_i.step) begin
      priority if (step_i.res_v && pend_v_q) begin
        push        = 1'b1;
        pend_d      = step_i.res;
        pend_last_d = step_i.done;
      end else if (step_i.res_v && step_i.done) begin
        push      = 1'b1;
        push_res  = step_i.res;
        push_last = 1'b1;
      end else if (step_i.res_v) begin
        pend_v_d = 1'b1;
        pend_d   = step_i.res;
      end else if (step_i.done && pend_v_q) begin
        push      = 1'b1;
        push_last = 1'b1;
        pend_v_d  = 1'b0;
      end else begin
        pend_v_d = pend_v_q;
      end
    end
  end

  // Output register
  always_comb begin
    out_v_d    = out_v_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    if (push) begin
      out_v_d    = 1'b1;
      out_d      = push_res;
      out_last_d = push_last;
    end else if (m_axis_tready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q    <= 1'b0;
      pend_last_q <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      pend_v_q    <= pend_v_d;
      pend_last_q <= pend_last_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {3'b000, out_q.valid, out_q.found, out_q.idx, out_q.ch};

  `DSS_ASSERT_IMPL(a_pend_last_held, clk_i, rst_ni, pend_last_q, pend_v_q, "final flag without pending result")
  `DSS_ASSERT_IMPL(a_step_when_ready, clk_i, rst_ni, step_i.step, out_free && !pend_last_q, "engine stepped while output blocked")

endmodule

`default_nettype wire

@@ src/delimiter_string_splitter.sv @@
// Path: input queue, engine, output register; a multi-result item also uses the pending slot.
// Throughput: one character per cycle while the output accepts and no final result is pending;
//   extra engine steps go to delimiter checks or held characters after a delimiter change.
// A terminator releases each held character, then closes an open token, then reports.
// For an item with more than one result, the engine waits while its final one is released.
// Reset: asynchronous, clears queue, token state and output; registers go to 1, 0x20, 8.
// ----------------------------------------------------------------------------
// Delimiter string splitter
// Splits a character stream into tokens on a multi-byte delimiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module delimiter_string_splitter (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [dss_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [dss_pkg::DelimBytesW-1:0]    cfg_data_i,
  // Input stream
  input  wire logic                               s_axis_tvalid_i,
  output      logic                               s_axis_tready_o,
  input  wire logic [dss_pkg::CharW-1:0]          s_axis_tdata_i,  // [7:0] text_char
  input  wire logic                               s_axis_tlast_i,  // end_of_text
  // Output stream
  output      logic                               m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  output      logic [dss_pkg::OutDataW-1:0]       m_axis_tdata_o,  // [7:0] out_char,
                                                                   // [13:8] element_index,
                                                                   // [19:14] elements_found,
                                                                   // [20] count_valid
  output      logic [dss_pkg::KindW-1:0]          m_axis_tuser_o,  // [1:0] kind
  output      logic                               m_axis_tlast_o   // last
);

  logic [dss_pkg::LenW-1:0]        delim_len_q;
  logic [dss_pkg::DelimBytesW-1:0] delim_bytes_q;
  logic [dss_pkg::SlotW-1:0]       slots_q;
  dss_pkg::cfg_t                   cfg;
  logic                            q_valid;
  dss_pkg::item_t                  q_item;
  logic                            q_pop;
  logic                            go;
  dss_pkg::step_t                  step;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_len_q   <= dss_pkg::DelimLenRst;
      delim_bytes_q <= dss_pkg::DelimBytesRst;
      slots_q       <= dss_pkg::SlotsRst;
    end else if (cfg_we_i) begin
      unique case (dss_pkg::cfg_idx_e'(cfg_idx_i))
        dss_pkg::CFG_DELIM_LEN: begin
          delim_len_q <= cfg_data_i[dss_pkg::LenW-1:0];
        end
        dss_pkg::CFG_DELIM_BYTES: begin
          delim_bytes_q <= cfg_data_i;
        end
        dss_pkg::CFG_OUT_SLOTS: begin
          slots_q <= cfg_data_i[dss_pkg::SlotW-1:0];
        end
        default: begin
          delim_len_q <= delim_len_q;
        end
      endcase
    end
  end

  // Clamp the register values into their working ranges
  always_comb begin
    cfg.delim_len   = dss_pkg::eff_len(delim_len_q);
    cfg.delim_bytes = delim_bytes_q;
    cfg.slots       = dss_pkg::eff_slots(slots_q);
  end

  dss_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  dss_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .go_i      (go),
    .step_o    (step)
  );

  dss_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .ready_o         (go),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
